@@ design/aws_pkg.sv @@
// Shared constants, types and helpers for the affine warp stitch addresser.
// No dependencies; every other design file refers to it by scoped names.
package aws_pkg;

    // Fixed field widths
    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_W       = 32;
    localparam int DIM_W        = 16;
    localparam int PIX_W        = 8;
    localparam int ACT_W        = 2;
    localparam int DIMS_W       = 24;
    localparam int DIMS_FIELD_W = 12;
    localparam int DATA_W       = 32;
    localparam int REG_IDX_W    = 3;
    localparam int ADDR_W       = REG_IDX_W + 2;

    // Datapath widths: coef times a nonnegative coordinate, sum of two products
    // plus a shift, and the integer part after flooring
    localparam int PROD_W = COEF_W + COORD_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int FLR_W  = SUM_W - FRAC_BITS;
    localparam int WIDE_W = FLR_W + 1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PLAN  = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_LEFT  = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_RIGHT = ACT_W'(2);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_COEF_XX    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_COEF_XY    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_COEF_YX    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_COEF_YY    = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_X    = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y    = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_LEFT_DIMS  = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_DIMS = REG_IDX_W'(7);

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [COORD_BITS-1:0]    t_coord;
    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic [DIM_W-1:0]         t_dim;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [FLR_W-1:0]  t_flr;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_coef COEF_ONE = t_coef'(1 << FRAC_BITS);
    localparam t_wide WIDE_SAT = t_wide'((1 << DIM_W) - 1);

    typedef struct packed {
        t_coef  coef_xx;
        t_coef  coef_xy;
        t_coef  coef_yx;
        t_coef  coef_yy;
        t_coef  shift_x;
        t_coef  shift_y;
        t_coord left_cols;
        t_coord left_rows;
        t_coord right_cols;
        t_coord right_rows;
    } t_cfg;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        t_coord           col;
        t_coord           row;
        t_pix             pix;
    } t_item;

    typedef struct packed {
        logic  v;
        t_item item;
        t_prod px_c;
        t_prod px_r;
        t_prod py_c;
        t_prod py_r;
    } t_prod_stage;

    // Corner k: bit 0 selects the last column, bit 1 the last row
    typedef struct packed {
        logic            v;
        t_item           item;
        t_flr [3:0]      fx;
        t_flr [3:0]      fy;
    } t_corner_stage;

    typedef struct packed {
        logic             v;
        logic [ACT_W-1:0] action;
        t_pix             pix;
        t_flr             dst_c;
        t_flr             dst_r;
        t_flr             min_x;
        t_flr             max_x;
        t_flr             min_y;
        t_flr             max_y;
    } t_box_stage;

    function automatic t_flr min_flr(input t_flr a, input t_flr b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_flr max_flr(input t_flr a, input t_flr b);
        return (a > b) ? a : b;
    endfunction

    // Clamp to the 16-bit size range
    function automatic t_dim sat_dim(input t_wide v);
        t_dim res;
        if (v < t_wide'(0)) begin
            res = '0;
        end else if (v > WIDE_SAT) begin
            res = '1;
        end else begin
            res = v[DIM_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/aws_cfg_regs.sv @@
// Register file behind the APB-style configuration port: map coefficients,
// shifts and image dimensions. Depends on aws_pkg.
module aws_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aws_pkg::ADDR_W-1:0]  paddr,
    input  logic [aws_pkg::DATA_W-1:0]  pwdata,
    output logic                        pready,
    output logic [aws_pkg::DATA_W-1:0]  prdata,
    output aws_pkg::t_cfg               o_cfg
);

    aws_pkg::t_coef                    r_coef_xx, r_coef_xy, r_coef_yx, r_coef_yy;
    aws_pkg::t_coef                    r_shift_x, r_shift_y;
    logic [aws_pkg::DIMS_W-1:0]        r_left_dims, r_right_dims;
    logic [aws_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[aws_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx    <= aws_pkg::COEF_ONE;
            r_coef_xy    <= '0;
            r_coef_yx    <= '0;
            r_coef_yy    <= aws_pkg::COEF_ONE;
            r_shift_x    <= '0;
            r_shift_y    <= '0;
            r_left_dims  <= '0;
            r_right_dims <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                aws_pkg::REG_COEF_XX:    r_coef_xx    <= pwdata;
                aws_pkg::REG_COEF_XY:    r_coef_xy    <= pwdata;
                aws_pkg::REG_COEF_YX:    r_coef_yx    <= pwdata;
                aws_pkg::REG_COEF_YY:    r_coef_yy    <= pwdata;
                aws_pkg::REG_SHIFT_X:    r_shift_x    <= pwdata;
                aws_pkg::REG_SHIFT_Y:    r_shift_y    <= pwdata;
                aws_pkg::REG_LEFT_DIMS:  r_left_dims  <= pwdata[aws_pkg::DIMS_W-1:0];
                aws_pkg::REG_RIGHT_DIMS: r_right_dims <= pwdata[aws_pkg::DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            aws_pkg::REG_COEF_XX:    prdata = r_coef_xx;
            aws_pkg::REG_COEF_XY:    prdata = r_coef_xy;
            aws_pkg::REG_COEF_YX:    prdata = r_coef_yx;
            aws_pkg::REG_COEF_YY:    prdata = r_coef_yy;
            aws_pkg::REG_SHIFT_X:    prdata = r_shift_x;
            aws_pkg::REG_SHIFT_Y:    prdata = r_shift_y;
            aws_pkg::REG_LEFT_DIMS:  prdata = aws_pkg::DATA_W'(r_left_dims);
            aws_pkg::REG_RIGHT_DIMS: prdata = aws_pkg::DATA_W'(r_right_dims);
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.coef_xx    = r_coef_xx;
        o_cfg.coef_xy    = r_coef_xy;
        o_cfg.coef_yx    = r_coef_yx;
        o_cfg.coef_yy    = r_coef_yy;
        o_cfg.shift_x    = r_shift_x;
        o_cfg.shift_y    = r_shift_y;
        o_cfg.left_cols  = r_left_dims[aws_pkg::COORD_BITS-1:0];
        o_cfg.left_rows  = r_left_dims[aws_pkg::DIMS_FIELD_W +: aws_pkg::COORD_BITS];
        o_cfg.right_cols = r_right_dims[aws_pkg::COORD_BITS-1:0];
        o_cfg.right_rows = r_right_dims[aws_pkg::DIMS_FIELD_W +: aws_pkg::COORD_BITS];
    end

endmodule

@@ design/aws_map_pipe.sv @@
// Front of the pipeline: input register, the four shared coefficient
// multipliers, and the floored corner / pixel sums. Depends on aws_pkg.
module aws_map_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aws_pkg::t_item        i_item,
    input  aws_pkg::t_cfg         i_cfg,
    input  logic                  i_ready,
    output logic                  o_stall,
    output aws_pkg::t_corner_stage o_stage
);

    logic                    r_in_v;
    aws_pkg::t_item          r_in;
    aws_pkg::t_prod_stage    r_prod, n_prod;
    aws_pkg::t_corner_stage  r_crn, n_crn;
    logic                    rdy_in, rdy_prod, rdy_crn;
    aws_pkg::t_coord         col_op, row_op;
    aws_pkg::t_sum           sx0, sx1, sx2, sx3, sy0, sy1, sy2, sy3;

    assign rdy_crn  = !r_crn.v || i_ready;
    assign rdy_prod = !r_prod.v || rdy_crn;
    assign rdy_in   = !r_in_v || rdy_prod;
    assign o_stall  = !rdy_in;
    assign o_stage  = r_crn;

    // A plan feeds the last left column and row into the multipliers;
    // a pixel feeds its own coordinates.
    always_comb begin
        if (r_in.action == aws_pkg::ACT_PLAN) begin
            col_op = i_cfg.left_cols - aws_pkg::t_coord'(1);
            row_op = i_cfg.left_rows - aws_pkg::t_coord'(1);
        end else begin
            col_op = r_in.col;
            row_op = r_in.row;
        end
        n_prod.v    = r_in_v;
        n_prod.item = r_in;
        n_prod.px_c = i_cfg.coef_xx * $signed({1'b0, col_op});
        n_prod.px_r = i_cfg.coef_xy * $signed({1'b0, row_op});
        n_prod.py_c = i_cfg.coef_yx * $signed({1'b0, col_op});
        n_prod.py_r = i_cfg.coef_yy * $signed({1'b0, row_op});
    end

    always_comb begin
        sx0 = aws_pkg::t_sum'(i_cfg.shift_x);
        sx1 = sx0 + aws_pkg::t_sum'(r_prod.px_c);
        sx2 = sx0 + aws_pkg::t_sum'(r_prod.px_r);
        sx3 = sx1 + aws_pkg::t_sum'(r_prod.px_r);
        sy0 = aws_pkg::t_sum'(i_cfg.shift_y);
        sy1 = sy0 + aws_pkg::t_sum'(r_prod.py_c);
        sy2 = sy0 + aws_pkg::t_sum'(r_prod.py_r);
        sy3 = sy1 + aws_pkg::t_sum'(r_prod.py_r);
        n_crn.v    = r_prod.v;
        n_crn.item = r_prod.item;
        // floor toward minus infinity: drop the fraction bits
        n_crn.fx[0] = sx0[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fx[1] = sx1[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fx[2] = sx2[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fx[3] = sx3[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fy[0] = sy0[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fy[1] = sy1[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fy[2] = sy2[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
        n_crn.fy[3] = sy3[aws_pkg::SUM_W-1:aws_pkg::FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_prod.v <= 1'b0;
            r_crn.v  <= 1'b0;
        end else begin
            if (rdy_in) begin
                r_in_v <= i_valid;
                r_in   <= i_item;
            end
            if (rdy_prod) begin
                r_prod <= n_prod;
            end
            if (rdy_crn) begin
                r_crn <= n_crn;
            end
        end
    end

endmodule

@@ design/aws_plan_box.sv @@
// Bounding box stage: min / max over the mapped corners and the right image
// extent, and the pre-offset destination of a pixel. Depends on aws_pkg.
module aws_plan_box (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  aws_pkg::t_corner_stage i_stage,
    input  aws_pkg::t_cfg          i_cfg,
    input  logic                   i_ready,
    output logic                   o_ready,
    output aws_pkg::t_box_stage    o_stage
);

    aws_pkg::t_box_stage r_box, n_box;
    logic                left_ok;
    aws_pkg::t_flr       min_x, max_x, min_y, max_y;
    aws_pkg::t_flr       base_max_x, base_max_y;

    assign o_ready = !r_box.v || i_ready;
    assign o_stage = r_box;
    assign left_ok = (i_cfg.left_cols != '0) && (i_cfg.left_rows != '0);

    always_comb begin
        base_max_x = $signed(aws_pkg::FLR_W'(i_cfg.right_cols)) - aws_pkg::t_flr'(1);
        base_max_y = $signed(aws_pkg::FLR_W'(i_cfg.right_rows)) - aws_pkg::t_flr'(1);
        min_x = aws_pkg::min_flr(
            aws_pkg::min_flr($signed(i_stage.fx[0]), $signed(i_stage.fx[1])),
            aws_pkg::min_flr($signed(i_stage.fx[2]), $signed(i_stage.fx[3])));
        max_x = aws_pkg::max_flr(
            aws_pkg::max_flr($signed(i_stage.fx[0]), $signed(i_stage.fx[1])),
            aws_pkg::max_flr($signed(i_stage.fx[2]), $signed(i_stage.fx[3])));
        min_y = aws_pkg::min_flr(
            aws_pkg::min_flr($signed(i_stage.fy[0]), $signed(i_stage.fy[1])),
            aws_pkg::min_flr($signed(i_stage.fy[2]), $signed(i_stage.fy[3])));
        max_y = aws_pkg::max_flr(
            aws_pkg::max_flr($signed(i_stage.fy[0]), $signed(i_stage.fy[1])),
            aws_pkg::max_flr($signed(i_stage.fy[2]), $signed(i_stage.fy[3])));

        n_box.v      = i_stage.v;
        n_box.action = i_stage.item.action;
        n_box.pix    = i_stage.item.pix;
        // an empty left image contributes no corners
        if (left_ok) begin
            n_box.min_x = aws_pkg::min_flr('0, min_x);
            n_box.min_y = aws_pkg::min_flr('0, min_y);
            n_box.max_x = aws_pkg::max_flr(base_max_x, max_x);
            n_box.max_y = aws_pkg::max_flr(base_max_y, max_y);
        end else begin
            n_box.min_x = '0;
            n_box.min_y = '0;
            n_box.max_x = base_max_x;
            n_box.max_y = base_max_y;
        end
        if (i_stage.item.action == aws_pkg::ACT_LEFT) begin
            n_box.dst_c = $signed(i_stage.fx[3]);
            n_box.dst_r = $signed(i_stage.fy[3]);
        end else begin
            n_box.dst_c = $signed(aws_pkg::FLR_W'(i_stage.item.col));
            n_box.dst_r = $signed(aws_pkg::FLR_W'(i_stage.item.row));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.v <= 1'b0;
        end else if (o_ready) begin
            r_box <= n_box;
        end
    end

endmodule

@@ design/aws_place.sv @@
// Final stage: offsets and mosaic size from a plan, bounds check of a pixel
// write, and the output register. Depends on aws_pkg.
module aws_place (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aws_pkg::t_box_stage  i_stage,
    input  logic                 i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic                 o_write_valid,
    output aws_pkg::t_dim        o_dest_col,
    output aws_pkg::t_dim        o_dest_row,
    output aws_pkg::t_pix        o_pixel_out,
    output aws_pkg::t_dim        o_frame_width,
    output aws_pkg::t_dim        o_frame_height
);

    aws_pkg::t_dim  r_offset_col, r_offset_row, r_mosaic_width, r_mosaic_height;
    aws_pkg::t_dim  n_offset_col, n_offset_row, n_mosaic_width, n_mosaic_height;
    logic           r_out_v;
    logic           r_write_valid, n_write_valid;
    aws_pkg::t_dim  r_dest_col, r_dest_row, n_dest_col, n_dest_row;
    aws_pkg::t_pix  r_pixel_out, n_pixel_out;
    aws_pkg::t_wide dc, dr;
    logic           is_pixel, in_bounds;

    function automatic aws_pkg::t_wide widen_dim(input aws_pkg::t_dim v);
        return aws_pkg::t_wide'({1'b0, v});
    endfunction

    assign o_ready        = !r_out_v || !i_stall;
    assign o_valid        = r_out_v;
    assign o_write_valid  = r_write_valid;
    assign o_dest_col     = r_dest_col;
    assign o_dest_row     = r_dest_row;
    assign o_pixel_out    = r_pixel_out;
    assign o_frame_width  = r_mosaic_width;
    assign o_frame_height = r_mosaic_height;

    always_comb begin
        n_offset_col    = r_offset_col;
        n_offset_row    = r_offset_row;
        n_mosaic_width  = r_mosaic_width;
        n_mosaic_height = r_mosaic_height;
        if (i_stage.action == aws_pkg::ACT_PLAN) begin
            // the box minimum is never positive, so its negation is the offset
            n_offset_col   = aws_pkg::sat_dim(-aws_pkg::t_wide'(i_stage.min_x));
            n_offset_row   = aws_pkg::sat_dim(-aws_pkg::t_wide'(i_stage.min_y));
            n_mosaic_width = aws_pkg::sat_dim(aws_pkg::t_wide'(i_stage.max_x)
                             + widen_dim(n_offset_col) + aws_pkg::t_wide'(1));
            n_mosaic_height = aws_pkg::sat_dim(aws_pkg::t_wide'(i_stage.max_y)
                             + widen_dim(n_offset_row) + aws_pkg::t_wide'(1));
        end
    end

    always_comb begin
        dc = aws_pkg::t_wide'(i_stage.dst_c) + widen_dim(r_offset_col);
        dr = aws_pkg::t_wide'(i_stage.dst_r) + widen_dim(r_offset_row);
        is_pixel = (i_stage.action == aws_pkg::ACT_LEFT)
                || (i_stage.action == aws_pkg::ACT_RIGHT);
        in_bounds = (dc >= aws_pkg::t_wide'(0)) && (dc < widen_dim(r_mosaic_width))
                 && (dr >= aws_pkg::t_wide'(0)) && (dr < widen_dim(r_mosaic_height));
        n_write_valid = is_pixel && in_bounds;
        n_dest_col    = n_write_valid ? dc[aws_pkg::DIM_W-1:0] : '0;
        n_dest_row    = n_write_valid ? dr[aws_pkg::DIM_W-1:0] : '0;
        n_pixel_out   = n_write_valid ? i_stage.pix : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v         <= 1'b0;
            r_offset_col    <= '0;
            r_offset_row    <= '0;
            r_mosaic_width  <= '0;
            r_mosaic_height <= '0;
        end else if (o_ready) begin
            r_out_v <= i_stage.v;
            if (i_stage.v) begin
                r_offset_col    <= n_offset_col;
                r_offset_row    <= n_offset_row;
                r_mosaic_width  <= n_mosaic_width;
                r_mosaic_height <= n_mosaic_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_stage.v) begin
            r_write_valid <= n_write_valid;
            r_dest_col    <= n_dest_col;
            r_dest_row    <= n_dest_row;
            r_pixel_out   <= n_pixel_out;
        end
    end

endmodule

@@ design/affine_warp_stitch_addresser.sv @@
// Top level of the affine warp stitch addresser: register file and the
// five-stage address pipeline. Depends on aws_pkg and the aws_* modules.
//
// Turns a stream of plan, left-pixel and right-pixel beats into one result
// beat each: a mosaic write command (or none) plus the current mosaic size.
// A beat is taken every clock while the output side keeps up; a result
// is presented after its beat passes the input register, multiplier
// register, corner-sum register, bounding-box register and output
// register. The rate is set by the four 32x13 coefficient multipliers,
// which serve both the plan corners and the left pixels and are used
// once per beat.
// While the output stalls, empty stages keep taking beats until every stage is full.
// A plan reads the configuration registers; write them only while no beat
// is in flight.
module affine_warp_stitch_addresser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aws_pkg::ADDR_W-1:0]      paddr,
    input  logic [aws_pkg::DATA_W-1:0]      pwdata,
    output logic                            pready,
    output logic [aws_pkg::DATA_W-1:0]      prdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [aws_pkg::ACT_W-1:0]       i_action,
    input  logic [aws_pkg::COORD_BITS-1:0]  i_src_col,
    input  logic [aws_pkg::COORD_BITS-1:0]  i_src_row,
    input  logic [aws_pkg::PIX_W-1:0]       i_pixel_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_write_valid,
    output logic [aws_pkg::DIM_W-1:0]       o_dest_col,
    output logic [aws_pkg::DIM_W-1:0]       o_dest_row,
    output logic [aws_pkg::PIX_W-1:0]       o_pixel_out,
    output logic [aws_pkg::DIM_W-1:0]       o_frame_width,
    output logic [aws_pkg::DIM_W-1:0]       o_frame_height
);

    aws_pkg::t_cfg          cfg;
    aws_pkg::t_item         item;
    aws_pkg::t_corner_stage crn_stage;
    aws_pkg::t_box_stage    box_stage;
    logic                   box_ready, place_ready;

    assign item.action = i_action;
    assign item.col    = i_src_col;
    assign item.row    = i_src_row;
    assign item.pix    = i_pixel_in;

    aws_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    aws_map_pipe u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (item),
        .i_cfg   (cfg),
        .i_ready (box_ready),
        .o_stall (o_stall),
        .o_stage (crn_stage)
    );

    aws_plan_box u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (crn_stage),
        .i_cfg   (cfg),
        .i_ready (place_ready),
        .o_ready (box_ready),
        .o_stage (box_stage)
    );

    aws_place u_place (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (box_stage),
        .i_stall        (i_stall),
        .o_ready        (place_ready),
        .o_valid        (o_valid),
        .o_write_valid  (o_write_valid),
        .o_dest_col     (o_dest_col),
        .o_dest_row     (o_dest_row),
        .o_pixel_out    (o_pixel_out),
        .o_frame_width  (o_frame_width),
        .o_frame_height (o_frame_height)
    );

endmodule
